/* rtl/core/k_mismatch_pattern_matcher_top_macros.svh */
`ifndef K_MISMATCH_PATTERN_MATCHER_TOP_MACROS_SVH
`define K_MISMATCH_PATTERN_MATCHER_TOP_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define KMM_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a trigger is followed by a condition in the next cycle.
`define KMM_ASSERT_NEXT(name, trig, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

/* rtl/core/kmm_pkg.sv */
`timescale 1ns / 1ps

package kmm_pkg;

   // Field widths of the streaming words.
   localparam int SymbolWidth = 8;
   localparam int IndexWidth  = 7;
   localparam int CountWidth  = 8;
   localparam int StartWidth  = 32;

   // Kind of an input word, carried in the lowest tuser bit.
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_REF  = 1'b1
   } op_type;

   // Register indexes of the configuration port.
   localparam logic [0:0] REG_MISMATCH_LIMIT = 1'b0;
   localparam logic [0:0] REG_PATTERN_LENGTH = 1'b1;

   // Control broadcast from the top level to every cell.
   typedef struct packed {
      logic                   step;
      logic                   scan;
      logic                   load;
      logic [IndexWidth-1:0]  load_index;
      logic [SymbolWidth-1:0] symbol;
      logic [CountWidth-1:0]  cap;
   } ctrl_type;

endpackage

/* rtl/core/kmm_cell.sv */
`timescale 1ns / 1ps

module kmm_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  kmm_pkg::ctrl_type              ctrl,
   input  logic [kmm_pkg::CountWidth-1:0] prev_count,
   input  logic                           prev_active,
   output logic [kmm_pkg::CountWidth-1:0] count,
   output logic                           active
);

   logic [kmm_pkg::SymbolWidth-1:0] pattern_ff;
   logic [kmm_pkg::CountWidth-1:0]  count_ff;
   logic [kmm_pkg::CountWidth-1:0]  count_in;
   logic                            active_ff;
   logic                            active_in;
   logic [kmm_pkg::CountWidth-1:0]  base_count;
   logic                            base_active;
   logic [kmm_pkg::CountWidth:0]    sum;

   // A new scan drops the window arriving from the left neighbor; the head
   // cell always opens a fresh window.
   always_comb begin
      if (ctrl.scan && (CELL_INDEX != 0)) begin
         base_count  = '0;
         base_active = 1'b0;
      end else begin
         base_count  = prev_count;
         base_active = prev_active;
      end
   end

   // Add one on a differing symbol and saturate at the cap.
   always_comb begin
      sum = {1'b0, base_count} + {{kmm_pkg::CountWidth{1'b0}},
                                  (ctrl.symbol != pattern_ff)};
      if (sum > {1'b0, ctrl.cap}) begin
         count_in = ctrl.cap;
      end else begin
         count_in = sum[kmm_pkg::CountWidth-1:0];
      end
      active_in = base_active;
   end

   // Pattern symbol of this position.
   always_ff @(posedge clock) begin
      if (ctrl.load && (int'(ctrl.load_index) == CELL_INDEX)) begin
         pattern_ff <= ctrl.symbol;
      end
   end

   // Window state moves one cell to the right on every reference word.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         active_ff <= 1'b0;
      end else if (ctrl.step) begin
         count_ff  <= count_in;
         active_ff <= active_in;
      end
   end

   assign count  = count_ff;
   assign active = active_ff;

endmodule

/* rtl/core/k_mismatch_pattern_matcher_top.sv */
// Streaming k-mismatch matcher. Words enter on the req_ channel: a load word
// (tuser bit 0 low) writes one pattern symbol at pattern_index; a reference
// word (tuser bit 0 high) shifts one symbol through a row of comparator cells,
// and tuser bit 1 on a reference word restarts the scan at position zero.
// For every window of pattern_length symbols that differs in no more than
// mismatch_limit symbols, one word leaves on the rsp_ channel with the start
// position and the mismatch count. The csr_ port writes the two registers; the
// user must use it only while the block is idle; the block does not enforce it.
// Throughput is one word per cycle while no match waits on a stalled receiver.
// From an accepted reference word to its result, the cells update at the
// accepting edge; the tap cell is then selected and compared, and a match is
// written into the output register once that register is free.
// Reset clears the windows, the position, both registers and the pipeline;
// pattern symbols hold whatever was last written.
// When the receiver stalls with a result waiting, one more matching word can
// sit in the compare stage; then req_tready drops until the output drains.
`timescale 1ns / 1ps

module k_mismatch_pattern_matcher_top #(
   parameter int PATTERN_MAX = 128,
   parameter int POS_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Input words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [6:0] pattern_index, [14:7] symbol, [15] zero
   input  logic [1:0]  req_tuser,  // [0] op, [1] scan_start
   // Result words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] match_start, [39:32] mismatch_count
   // Register writes.
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int TapWidth = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam logic [POS_WIDTH-1:0] PosMax = {POS_WIDTH{1'b1}};

   logic [kmm_pkg::CountWidth-1:0] limit_ff;
   logic [7:0]                     length_ff;

   kmm_pkg::ctrl_type              ctrl;
   logic [kmm_pkg::CountWidth-1:0] cell_count  [PATTERN_MAX];
   logic                           cell_active [PATTERN_MAX];

   logic                           req_fire;
   logic                           ref_fire;
   logic                           scan_now;
   logic [POS_WIDTH-1:0]           pos_ff;
   logic [POS_WIDTH-1:0]           pos_in;
   logic [POS_WIDTH-1:0]           pos_base;

   logic                           s1_ff;
   logic [POS_WIDTH-1:0]           s1_pos_ff;
   logic                           s1_hit;
   logic                           s1_move;

   logic [TapWidth-1:0]            tap_idx;
   logic [POS_WIDTH-1:0]           tap_back;
   logic [kmm_pkg::CountWidth-1:0] tap_count;
   logic [POS_WIDTH-1:0]           start_full;

   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic [39:0]                    out_data_ff;
   logic                           out_free;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= '0;
         length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            kmm_pkg::REG_MISMATCH_LIMIT: limit_ff  <= csr_wdata;
            kmm_pkg::REG_PATTERN_LENGTH: length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake and the broadcast control word.
   assign req_fire = req_tvalid && req_tready;
   assign ref_fire = req_fire && (req_tuser[0] == kmm_pkg::OP_REF);
   assign scan_now = ref_fire && req_tuser[1];

   always_comb begin
      ctrl.step       = ref_fire;
      ctrl.scan       = scan_now;
      ctrl.load       = req_fire && (req_tuser[0] == kmm_pkg::OP_LOAD);
      ctrl.load_index = req_tdata[6:0];
      ctrl.symbol     = req_tdata[14:7];
      ctrl.cap        = (limit_ff == 8'hFF) ? 8'hFF : (limit_ff + 8'd1);
   end

   // Row of comparator cells; the head takes a fresh window each word.
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      if (j == 0) begin : g_head
         kmm_cell #(.CELL_INDEX(j)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .prev_count  ('0),
            .prev_active (1'b1),
            .count       (cell_count[j]),
            .active      (cell_active[j])
         );
      end else begin : g_body
         kmm_cell #(.CELL_INDEX(j)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .prev_count  (cell_count[j-1]),
            .prev_active (cell_active[j-1]),
            .count       (cell_count[j]),
            .active      (cell_active[j])
         );
      end
   end

   // Reference position: the word's own position and the next one.
   always_comb begin
      pos_base = scan_now ? '0 : pos_ff;
      pos_in   = (pos_base == PosMax) ? pos_base : (pos_base + POS_WIDTH'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (ref_fire) begin
         pos_ff <= pos_in;
      end
   end

   // Tap cell at the end of the pattern; lengths past the row use the last cell.
   always_comb begin
      if (int'(length_ff) >= PATTERN_MAX) begin
         tap_idx  = TapWidth'(PATTERN_MAX - 1);
         tap_back = POS_WIDTH'(PATTERN_MAX - 1);
      end else begin
         tap_idx  = TapWidth'(int'(length_ff) - 1);
         tap_back = POS_WIDTH'(int'(length_ff) - 1);
      end
      tap_count  = cell_count[tap_idx];
      s1_hit     = (length_ff != 8'd0) && cell_active[tap_idx] && (tap_count <= limit_ff);
      start_full = s1_pos_ff - tap_back;
   end

   // Compare stage: holds a reference word whose cells are up to date.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_ff && (!s1_hit || out_free);
   assign req_tready = !s1_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
      end else if (ref_fire) begin
         s1_ff <= 1'b1;
      end else if (s1_move) begin
         s1_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ref_fire) begin
         s1_pos_ff <= pos_base;
      end
   end

   // Output register.
   always_comb begin
      if (s1_move && s1_hit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_hit) begin
         out_data_ff <= {tap_count, kmm_pkg::StartWidth'(start_full)};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`include "k_mismatch_pattern_matcher_top_macros.svh"

   // A reported count never exceeds the limit.
   `KMM_ASSERT_ALWAYS(a_count_ok, !rsp_tvalid || (rsp_tdata[39:32] <= limit_ff), "count above limit")

   // A reference word always lands in the compare stage.
   `KMM_ASSERT_NEXT(a_ref_staged, ref_fire, s1_ff, "reference word not staged")

   // A new scan leaves the next position at one.
   `KMM_ASSERT_NEXT(a_scan_pos, scan_now, pos_ff == POS_WIDTH'(1), "scan restart position wrong")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int PatternMax    = 128;
   localparam int PosWidth      = 32;
   localparam int DrainCycles   = 8;
   localparam int WatchdogLimit = 2000;
   localparam int LongHoldOff   = 300;
   localparam int PhaseWords    = 120;

   // One reported window: where it starts and how many symbols differ.
   typedef struct {
      bit [31:0] start_pos;
      bit [7:0]  count;
   } match_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // [6:0] pattern_index, [14:7] symbol, [15] zero
   logic [1:0]  req_tuser = '0;  // [0] op, [1] scan_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // [31:0] match_start, [39:32] mismatch_count
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = kmm_pkg::REG_MISMATCH_LIMIT;
   logic [7:0]  csr_wdata = '0;

   // Own copy of the matcher state and its registers.
   bit [7:0]  pat_mem [PatternMax];
   bit [7:0]  win_count [PatternMax];
   bit        win_live [PatternMax];
   bit [31:0] ref_pos;
   bit [7:0]  cfg_limit;
   bit [7:0]  cfg_length;

   match_type pending_matches [$];
   match_type head_match;

   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   int idle_cycles = 0;
   int error_count = 0;
   int words_sent = 0;
   int matches_seen = 0;
   int config_writes = 0;

   k_mismatch_pattern_matcher_top #(
      .PATTERN_MAX(PatternMax),
      .POS_WIDTH  (PosWidth)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Count one more difference, holding at the saturation value.
   function automatic bit [7:0] bump_count(input bit [7:0] count, input bit differ,
                                           input int cap);
      int sum;
      sum = count + differ;
      return 8'((sum > cap) ? cap : sum);
   endfunction

   // Apply one accepted word to the model and queue any match it yields.
   task automatic update_windows(input kmm_pkg::op_type op, input bit [6:0] idx,
                                 input bit [7:0] sym, input bit scan);
      int cap;
      int span;
      bit [31:0] pos;
      match_type hit;
      if (op == kmm_pkg::OP_LOAD) begin
         pat_mem[idx] = sym;
         return;
      end
      if (scan) begin
         foreach (win_count[j]) begin
            win_count[j] = '0;
            win_live[j] = 1'b0;
         end
         ref_pos = '0;
      end
      cap = cfg_limit + 1;
      if (cap > 255) cap = 255;
      for (int j = PatternMax - 1; j > 0; j--) begin
         win_count[j] = bump_count(win_count[j - 1], sym != pat_mem[j], cap);
         win_live[j] = win_live[j - 1];
      end
      win_count[0] = bump_count(8'd0, sym != pat_mem[0], cap);
      win_live[0] = 1'b1;
      pos = ref_pos;
      if (ref_pos != '1) ref_pos++;
      span = (cfg_length > PatternMax) ? PatternMax : cfg_length;
      if (span == 0) return;
      if (win_live[span - 1] && win_count[span - 1] <= cfg_limit) begin
         hit.start_pos = pos - 32'(span - 1);
         hit.count = win_count[span - 1];
         pending_matches.insert(pending_matches.size(), hit);
      end
   endtask

   // Offer one word, idling first at random, and wait until it is taken.
   task automatic send_word(input kmm_pkg::op_type op, input bit [6:0] idx,
                            input bit [7:0] sym, input bit scan);
      if ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, sym, idx};
      req_tuser <= {scan, op};
      do @(posedge clock); while (!req_tready);
      update_windows(op, idx, sym, scan);
      words_sent++;
   endtask

   // Stop offering words and let every expected match come out.
   task automatic drain_matches();
      req_tvalid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write the limit register, then the length register, while the block is idle.
   task automatic set_config(input bit [7:0] limit, input bit [7:0] length);
      csr_we <= 1'b1;
      csr_index <= kmm_pkg::REG_MISMATCH_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      cfg_limit = limit;
      csr_index <= kmm_pkg::REG_PATTERN_LENGTH;
      csr_wdata <= length;
      @(posedge clock);
      cfg_length = length;
      csr_we <= 1'b0;
      config_writes++;
   endtask

   // Every pattern entry gets written before any reference word reads it.
   task automatic test_pattern_fill();
      set_config(8'd0, 8'd1);
      for (int j = 0; j < PatternMax; j++) begin
         send_word(kmm_pkg::OP_LOAD, 7'(j), 8'($urandom), 1'b0);
      end
      drain_matches();
   endtask

   // Exact hits, single mismatches, saturation, restart, zero and one length.
   task automatic test_directed_cases();
      set_config(8'd1, 8'd3);
      send_word(kmm_pkg::OP_LOAD, 7'd0, 8'h00, 1'b0);
      send_word(kmm_pkg::OP_LOAD, 7'd1, 8'hFF, 1'b1);
      send_word(kmm_pkg::OP_LOAD, 7'd2, 8'hA5, 1'b0);
      send_word(kmm_pkg::OP_LOAD, 7'd127, 8'hFF, 1'b0);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'h00, 1'b1);
      send_word(kmm_pkg::OP_REF, 7'd127, 8'hFF, 1'b0);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'hA5, 1'b0);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'h00, 1'b0);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'hFF, 1'b0);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'h00, 1'b0);
      // Every symbol differs here, so the counts run into saturation.
      send_word(kmm_pkg::OP_REF, 7'd0, 8'h11, 1'b0);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'h22, 1'b0);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'h33, 1'b0);
      // A restart in mid-stream drops the live windows and the position.
      send_word(kmm_pkg::OP_REF, 7'd0, 8'h00, 1'b1);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'hFF, 1'b0);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'hA5, 1'b0);
      drain_matches();
      set_config(8'd0, 8'd0);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'h00, 1'b1);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'hFF, 1'b0);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'hA5, 1'b0);
      drain_matches();
      set_config(8'd128, 8'd1);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'hFF, 1'b1);
      send_word(kmm_pkg::OP_REF, 7'd0, 8'h00, 1'b0);
      drain_matches();
   endtask

   // Mostly planted copies of the pattern with a few symbols replaced,
   // mixed with random symbols and pattern rewrites.
   task automatic run_random_stream(input int word_budget);
      int sent;
      int span;
      int flips;
      int pick;
      bit [7:0] window [PatternMax];
      sent = 0;
      span = (cfg_length > PatternMax) ? PatternMax : cfg_length;
      if (span == 0) span = $urandom_range(1, 8);
      while (sent < word_budget) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            for (int j = 0; j < span; j++) window[j] = pat_mem[j];
            flips = $urandom_range(0, cfg_limit + 2);
            repeat (flips) window[$urandom_range(span - 1)] = 8'($urandom);
            for (int j = 0; j < span; j++) begin
               send_word(kmm_pkg::OP_REF, 7'($urandom), window[j],
                         j == 0 && $urandom_range(7) == 0);
               sent++;
            end
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 6)) begin
               send_word(kmm_pkg::OP_REF, 7'($urandom), 8'($urandom),
                         $urandom_range(15) == 0);
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               send_word(kmm_pkg::OP_LOAD, ($urandom_range(3) == 0) ? 7'($urandom)
                                                           : 7'($urandom_range(span - 1)),
                         8'($urandom), 1'($urandom));
               sent++;
            end
         end
      end
   endtask

   // Three idling modes, each run through three register settings.
   task automatic test_random_scans();
      int limits [9] = '{1, 128, 0, 2, 0, 5, 3, 0, 128};
      int lengths [9] = '{4, 128, 1, 8, 0, 32, 16, 2, 1};
      int send_gaps [3] = '{29, 87, 0};
      int recv_stalls [3] = '{87, 29, 0};
      for (int m = 0; m < 3; m++) begin
         req_gap_pct = send_gaps[m];
         rsp_stall_pct = recv_stalls[m];
         for (int c = 0; c < 3; c++) begin
            drain_matches();
            set_config(8'(limits[m * 3 + c]), 8'(lengths[m * 3 + c]));
            run_random_stream(PhaseWords);
         end
      end
      drain_matches();
   endtask

   // The receiver holds off for a long stretch while every word yields a
   // match, so the block fills up and must stall its input.
   task automatic test_backpressure();
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      set_config(8'd128, 8'd1);
      rsp_hold_left = LongHoldOff;
      repeat (40) send_word(kmm_pkg::OP_REF, 7'($urandom), 8'($urandom), 1'b0);
      drain_matches();
   endtask

   // Receiver side: a long hold-off when asked, else random stalls.
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare each accepted result with the oldest expected match.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            $display("%0t: unexpected result start %0d count %0d", $time,
                     rsp_tdata[31:0], rsp_tdata[39:32]);
            error_count++;
         end else begin
            head_match = pending_matches.pop_front();
            matches_seen++;
            if (rsp_tdata[31:0] !== head_match.start_pos) begin
               $display("%0t: match_start expected %0d, got %0d", $time,
                        head_match.start_pos, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[39:32] !== head_match.count) begin
               $display("%0t: mismatch_count expected %0d, got %0d", $time,
                        head_match.count, rsp_tdata[39:32]);
               error_count++;
            end
         end
      end
   end

   // End the run when nothing has moved for too long.
   always @(posedge clock) begin
      if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("Verification failed");
         $finish;
      end else if (reset || csr_we || (req_tvalid && req_tready)
                   || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_pattern_fill();
      test_directed_cases();
      test_random_scans();
      test_backpressure();
      $display("Run covered %0d words in, %0d matches checked, %0d register settings.",
               words_sent, matches_seen, config_writes);
      $display("Limits 0 to 128, lengths 0 to 128, three idling modes and a long stall.");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* k_mismatch_pattern_matcher_top.f */
+incdir+rtl/core
rtl/core/kmm_pkg.sv
rtl/core/kmm_cell.sv
rtl/core/k_mismatch_pattern_matcher_top.sv
tb/sv/testbench.sv
